@@ sv/iot_pkg.sv @@
// Shared constants, codes and types of the order tracker.
`default_nettype none
package iot_pkg;
   localparam int ORDER_SLOTS    = 256;
   localparam int SLOT_W         = $clog2(ORDER_SLOTS);
   localparam int SCAN_W         = SLOT_W + 1;
   localparam int LOCATE_ENTRIES = 8192;
   localparam int LOC_W          = $clog2(LOCATE_ENTRIES);

   localparam logic [2:0] FN_ADD     = 3'd0;
   localparam logic [2:0] FN_EXEC    = 3'd1;
   localparam logic [2:0] FN_CANCEL  = 3'd2;
   localparam logic [2:0] FN_DELETE  = 3'd3;
   localparam logic [2:0] FN_REPLACE = 3'd4;
   localparam logic [2:0] FN_TRADE   = 3'd5;
   localparam logic [2:0] FN_DIR     = 3'd6;

   localparam logic [2:0] EV_ADD        = 3'd0;
   localparam logic [2:0] EV_UPDATE     = 3'd1;
   localparam logic [2:0] EV_DELETE     = 3'd2;
   localparam logic [2:0] EV_TRADE      = 3'd3;
   localparam logic [2:0] EV_TICK_SIZE  = 3'd4;
   localparam logic [2:0] EV_TRADE_TICK = 3'd5;

   localparam logic [1:0] SC_ABSENT = 2'd0;
   localparam logic [1:0] SC_BUY    = 2'd1;
   localparam logic [1:0] SC_SELL   = 2'd2;

   localparam logic [1:0] AGG_UNKNOWN = 2'd0;
   localparam logic [1:0] AGG_BUY     = 2'd1;
   localparam logic [1:0] AGG_SELL    = 2'd2;

   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   localparam logic [31:0] TICK_SIZE = 32'd100;

   typedef struct packed {
      logic [63:0] ref_no;
      logic [63:0] sym;
      logic [31:0] remaining;
      logic        side;
      logic [31:0] price;
   } entry_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] sym;
   } loc_entry_type;

   typedef struct packed {
      logic       capture;
      logic       clear;
      logic       scan_start;
      logic       key_orig;
      logic       scan_run;
      logic       loc_read;
      logic       take_loc;
      logic       place;
      logic       reduce;
      logic       drop;
      logic       dir_write;
      logic       load;
      logic [2:0] kind;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       has_sym;
      logic       sc_zero;
      logic       clr_last;
      logic       scan_done;
      logic       found;
      logic       del;
      logic       resolved;
      logic       out_free;
   } sts_type;
endpackage
`default_nettype wire

@@ sv/iot_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module iot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ sv/iot_dp.sv @@
// Datapath: message registers, order table scan, locate table and result register.
`default_nettype none
module iot_dp (
   input  logic                clock,
   input  logic                reset,
   input  iot_pkg::cmd_type    cmd,
   output iot_pkg::sts_type    sts,
   input  logic [2:0]          req_func,
   input  logic [63:0]         req_order_ref,
   input  logic [63:0]         req_orig_ref,
   input  logic [31:0]         req_shares,
   input  logic [31:0]         req_price,
   input  logic [1:0]          req_side_code,
   input  logic                req_has_symbol,
   input  logic [63:0]         req_symbol,
   input  logic [15:0]         req_locate,
   input  logic                req_has_seq,
   input  logic [63:0]         req_seq,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [2:0]          rsp_event_kind,
   output logic [63:0]         rsp_out_symbol,
   output logic [63:0]         rsp_out_order_ref,
   output logic [1:0]          rsp_out_side,
   output logic [31:0]         rsp_out_price,
   output logic [31:0]         rsp_out_shares,
   output logic                rsp_out_has_seq,
   output logic [63:0]         rsp_out_seq,
   output logic                rsp_last
);
   // message word
   logic [2:0]  m_func_ff;
   logic [63:0] m_ref_ff;
   logic [63:0] m_orig_ff;
   logic [31:0] m_shares_ff;
   logic [31:0] m_price_ff;
   logic [1:0]  m_sc_ff;
   logic        m_has_sym_ff;
   logic [15:0] m_loc_ff;
   logic        m_has_seq_ff;
   logic [63:0] m_seq_ff;
   logic [63:0] sym_ff;
   logic        side_ff;

   // scan
   logic [63:0]                key_ff;
   logic [iot_pkg::SCAN_W-1:0] scan_cnt_ff;
   logic                       pv_ff;
   logic [iot_pkg::SLOT_W-1:0] pidx_ff;
   logic                       found_ff;
   logic [iot_pkg::SLOT_W-1:0] found_idx_ff;
   logic                       free_ff;
   logic [iot_pkg::SLOT_W-1:0] free_idx_ff;
   iot_pkg::entry_type         ent_ff;
   logic                       del_ff;
   logic [31:0]                rem_ff;
   logic [iot_pkg::SLOT_W-1:0] victim_ff;
   logic [iot_pkg::ORDER_SLOTS-1:0] slot_valid_ff;
   logic [iot_pkg::LOC_W-1:0]  clr_cnt_ff;

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  rsp_kind_ff;
   logic [63:0] rsp_sym_ff;
   logic [63:0] rsp_ref_ff;
   logic [1:0]  rsp_side_ff;
   logic [31:0] rsp_price_ff;
   logic [31:0] rsp_shares_ff;
   logic        rsp_has_seq_ff;
   logic [63:0] rsp_seq_ff;
   logic        rsp_last_ff;

   iot_pkg::entry_type     slot_rd;
   iot_pkg::entry_type     slot_wr;
   logic                   slot_we;
   logic [iot_pkg::SLOT_W-1:0] slot_waddr;
   logic                   scan_issue;
   logic                   hit;
   logic                   del_now;
   logic [31:0]            rem_new;
   logic [iot_pkg::SLOT_W-1:0] place_idx;
   logic                   use_victim;

   iot_pkg::loc_entry_type loc_rd;
   iot_pkg::loc_entry_type loc_wr;
   logic                   loc_we;
   logic [iot_pkg::LOC_W-1:0] loc_waddr;
   logic                   in_range;

   logic [1:0]  trade_side;
   logic [31:0] trade_price;
   logic [63:0] ev_ref;
   logic [1:0]  ev_side;
   logic [31:0] ev_price;
   logic [31:0] ev_shares;
   logic        ev_stamp;

   assign scan_issue = cmd.scan_run
                       && (scan_cnt_ff < iot_pkg::SCAN_W'(iot_pkg::ORDER_SLOTS));
   assign hit        = slot_valid_ff[pidx_ff] && (slot_rd.ref_no == key_ff);
   assign del_now    = m_shares_ff >= ent_ff.remaining;
   assign rem_new    = ent_ff.remaining - m_shares_ff;
   assign use_victim = !found_ff && !free_ff;
   assign place_idx  = found_ff ? found_idx_ff : (free_ff ? free_idx_ff : victim_ff);
   assign in_range   = {1'b0, m_loc_ff} < 17'(iot_pkg::LOCATE_ENTRIES);

   always_comb begin
      slot_we    = 1'b0;
      slot_waddr = place_idx;
      slot_wr    = ent_ff;
      if (cmd.place) begin
         slot_we        = 1'b1;
         slot_wr.ref_no = m_ref_ff;
         slot_wr.sym    = sym_ff;
         slot_wr.remaining = m_shares_ff;
         slot_wr.side   = side_ff;
         slot_wr.price  = m_price_ff;
      end else if (cmd.reduce && !del_now) begin
         slot_we    = 1'b1;
         slot_waddr = found_idx_ff;
         slot_wr.remaining = rem_new;
      end
   end

   iot_ram #(
      .WIDTH ($bits(iot_pkg::entry_type)),
      .DEPTH (iot_pkg::ORDER_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wr),
      .rd_en   (scan_issue),
      .rd_addr (scan_cnt_ff[iot_pkg::SLOT_W-1:0]),
      .rd_data (slot_rd)
   );

   always_comb begin
      loc_we        = 1'b0;
      loc_waddr     = m_loc_ff[iot_pkg::LOC_W-1:0];
      loc_wr.valid  = 1'b1;
      loc_wr.sym    = sym_ff;
      if (cmd.clear) begin
         loc_we       = 1'b1;
         loc_waddr    = clr_cnt_ff;
         loc_wr.valid = 1'b0;
         loc_wr.sym   = '0;
      end else if (cmd.dir_write && in_range) begin
         loc_we = 1'b1;
      end
   end

   iot_ram #(
      .WIDTH ($bits(iot_pkg::loc_entry_type)),
      .DEPTH (iot_pkg::LOCATE_ENTRIES)
   ) u_loc_ram (
      .clock   (clock),
      .wr_en   (loc_we),
      .wr_addr (loc_waddr),
      .wr_data (loc_wr),
      .rd_en   (cmd.loc_read),
      .rd_addr (m_loc_ff[iot_pkg::LOC_W-1:0]),
      .rd_data (loc_rd)
   );

   // message capture and working symbol / side
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         m_func_ff    <= req_func;
         m_ref_ff     <= req_order_ref;
         m_orig_ff    <= req_orig_ref;
         m_shares_ff  <= req_shares;
         m_price_ff   <= req_price;
         m_sc_ff      <= req_side_code;
         m_has_sym_ff <= req_has_symbol;
         m_loc_ff     <= req_locate;
         m_has_seq_ff <= req_has_seq;
         m_seq_ff     <= req_seq;
         sym_ff       <= req_symbol;
         side_ff      <= (req_side_code == iot_pkg::SC_BUY) ? iot_pkg::SIDE_BID
                                                            : iot_pkg::SIDE_ASK;
      end else if (cmd.take_loc) begin
         sym_ff <= loc_rd.sym;
      end else if (cmd.reduce) begin
         sym_ff <= ent_ff.sym;
      end else if (cmd.drop) begin
         sym_ff  <= ent_ff.sym;
         side_ff <= ent_ff.side;
      end
      if (cmd.reduce) begin
         del_ff <= del_now;
         rem_ff <= rem_new;
      end
   end

   // table scan: lowest matching valid slot and lowest free slot
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= iot_pkg::SCAN_W'(iot_pkg::ORDER_SLOTS);
         pv_ff       <= 1'b0;
         found_ff    <= 1'b0;
         free_ff     <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_cnt_ff <= '0;
         pv_ff       <= 1'b0;
         found_ff    <= 1'b0;
         free_ff     <= 1'b0;
         key_ff      <= cmd.key_orig ? m_orig_ff : m_ref_ff;
      end else if (cmd.scan_run) begin
         pv_ff   <= scan_issue;
         pidx_ff <= scan_cnt_ff[iot_pkg::SLOT_W-1:0];
         if (scan_issue) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         if (pv_ff && hit && !found_ff) begin
            found_ff     <= 1'b1;
            found_idx_ff <= pidx_ff;
            ent_ff       <= slot_rd;
         end
         if (pv_ff && !slot_valid_ff[pidx_ff] && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= pidx_ff;
         end
      end
   end

   // valid bits, victim rotation and locate clear pass
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         victim_ff     <= '0;
         clr_cnt_ff    <= '0;
      end else begin
         if (cmd.place) begin
            slot_valid_ff[place_idx] <= 1'b1;
            if (use_victim) begin
               victim_ff <= (victim_ff == iot_pkg::SLOT_W'(iot_pkg::ORDER_SLOTS - 1))
                            ? '0 : victim_ff + 1'b1;
            end
         end
         if ((cmd.reduce && del_now) || cmd.drop) begin
            slot_valid_ff[found_idx_ff] <= 1'b0;
         end
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (m_func_ff == iot_pkg::FN_EXEC) begin
         trade_price = ent_ff.price;
         trade_side  = (ent_ff.side == iot_pkg::SIDE_BID) ? iot_pkg::AGG_SELL
                                                          : iot_pkg::AGG_BUY;
      end else begin
         trade_price = m_price_ff;
         priority if (m_sc_ff == iot_pkg::SC_BUY) begin
            trade_side = iot_pkg::AGG_BUY;
         end else if (m_sc_ff == iot_pkg::SC_SELL) begin
            trade_side = iot_pkg::AGG_SELL;
         end else begin
            trade_side = iot_pkg::AGG_UNKNOWN;
         end
      end
   end

   always_comb begin
      ev_ref    = '0;
      ev_side   = '0;
      ev_price  = '0;
      ev_shares = '0;
      unique case (cmd.kind)
         iot_pkg::EV_ADD: begin
            ev_ref    = m_ref_ff;
            ev_side   = {1'b0, side_ff};
            ev_price  = m_price_ff;
            ev_shares = m_shares_ff;
         end
         iot_pkg::EV_UPDATE: begin
            ev_ref    = m_ref_ff;
            ev_shares = rem_ff;
         end
         iot_pkg::EV_DELETE: begin
            ev_ref = (m_func_ff == iot_pkg::FN_REPLACE) ? m_orig_ff : m_ref_ff;
         end
         iot_pkg::EV_TRADE: begin
            ev_side   = trade_side;
            ev_price  = trade_price;
            ev_shares = m_shares_ff;
         end
         iot_pkg::EV_TICK_SIZE: begin
            ev_price = iot_pkg::TICK_SIZE;
         end
         iot_pkg::EV_TRADE_TICK: begin
            ev_price  = trade_price;
            ev_shares = m_shares_ff;
         end
         default: begin
            ev_ref = '0;
         end
      endcase
   end

   assign ev_stamp = m_has_seq_ff && (cmd.kind <= iot_pkg::EV_TRADE);

   // result word: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_kind_ff    <= cmd.kind;
         rsp_sym_ff     <= sym_ff;
         rsp_ref_ff     <= ev_ref;
         rsp_side_ff    <= ev_side;
         rsp_price_ff   <= ev_price;
         rsp_shares_ff  <= ev_shares;
         rsp_has_seq_ff <= ev_stamp;
         rsp_seq_ff     <= ev_stamp ? m_seq_ff : '0;
         rsp_last_ff    <= cmd.last;
      end
   end

   assign sts.func      = m_func_ff;
   assign sts.has_sym   = m_has_sym_ff;
   assign sts.sc_zero   = (m_sc_ff == iot_pkg::SC_ABSENT);
   assign sts.clr_last  = (clr_cnt_ff == iot_pkg::LOC_W'(iot_pkg::LOCATE_ENTRIES - 1));
   assign sts.scan_done = (scan_cnt_ff == iot_pkg::SCAN_W'(iot_pkg::ORDER_SLOTS)) && !pv_ff;
   assign sts.found     = found_ff;
   assign sts.del       = del_ff;
   assign sts.resolved  = in_range && loc_rd.valid;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = rsp_kind_ff;
   assign rsp_out_symbol    = rsp_sym_ff;
   assign rsp_out_order_ref = rsp_ref_ff;
   assign rsp_out_side      = rsp_side_ff;
   assign rsp_out_price     = rsp_price_ff;
   assign rsp_out_shares    = rsp_shares_ff;
   assign rsp_out_has_seq   = rsp_has_seq_ff;
   assign rsp_out_seq       = rsp_seq_ff;
   assign rsp_last          = rsp_last_ff;
endmodule
`default_nettype wire

@@ sv/iot_ctrl.sv @@
// Controller: sequences clear pass, lookups, table updates and event output.
`default_nettype none
module iot_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iot_pkg::sts_type sts,
   output iot_pkg::cmd_type cmd
);
   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_LRD      = 4'd3;
   localparam logic [3:0] S_LWT      = 4'd4;
   localparam logic [3:0] S_SCAN1    = 4'd5;
   localparam logic [3:0] S_DEC1     = 4'd6;
   localparam logic [3:0] S_SCAN2    = 4'd7;
   localparam logic [3:0] S_DEC2     = 4'd8;
   localparam logic [3:0] S_DIR      = 4'd9;
   localparam logic [3:0] S_E_ADD    = 4'd10;
   localparam logic [3:0] S_E_RED    = 4'd11;
   localparam logic [3:0] S_E_DEL    = 4'd12;
   localparam logic [3:0] S_E_TRADE  = 4'd13;
   localparam logic [3:0] S_E_TTICK  = 4'd14;
   localparam logic [3:0] S_E_TICK   = 4'd15;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.func)
               iot_pkg::FN_ADD: begin
                  priority if (sts.sc_zero) begin
                     state_in = S_IDLE;
                  end else if (sts.has_sym) begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN1;
                  end else begin
                     state_in = S_LRD;
                  end
               end
               iot_pkg::FN_EXEC, iot_pkg::FN_CANCEL, iot_pkg::FN_DELETE: begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN1;
               end
               iot_pkg::FN_REPLACE: begin
                  cmd.scan_start = 1'b1;
                  cmd.key_orig   = 1'b1;
                  state_in       = S_SCAN1;
               end
               iot_pkg::FN_TRADE: begin
                  state_in = sts.has_sym ? S_E_TRADE : S_LRD;
               end
               iot_pkg::FN_DIR: begin
                  state_in = sts.has_sym ? S_DIR : S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_LRD: begin
            cmd.loc_read = 1'b1;
            state_in     = S_LWT;
         end
         S_LWT: begin
            if (!sts.resolved) begin
               state_in = S_IDLE;
            end else begin
               cmd.take_loc = 1'b1;
               if (sts.func == iot_pkg::FN_ADD) begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN1;
               end else begin
                  state_in = S_E_TRADE;
               end
            end
         end
         S_SCAN1: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = S_DEC1;
            end
         end
         S_DEC1: begin
            unique case (sts.func)
               iot_pkg::FN_ADD: begin
                  cmd.place = 1'b1;
                  state_in  = S_E_ADD;
               end
               iot_pkg::FN_EXEC, iot_pkg::FN_CANCEL: begin
                  if (sts.found) begin
                     cmd.reduce = 1'b1;
                     state_in   = S_E_RED;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               iot_pkg::FN_DELETE, iot_pkg::FN_REPLACE: begin
                  if (sts.found) begin
                     cmd.drop = 1'b1;
                     state_in = S_E_DEL;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SCAN2: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = S_DEC2;
            end
         end
         S_DEC2: begin
            cmd.place = 1'b1;
            state_in  = S_E_ADD;
         end
         S_DIR: begin
            cmd.dir_write = 1'b1;
            state_in      = S_E_TICK;
         end
         S_E_ADD: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               cmd.kind = iot_pkg::EV_ADD;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_E_RED: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               cmd.kind = sts.del ? iot_pkg::EV_DELETE : iot_pkg::EV_UPDATE;
               cmd.last = (sts.func == iot_pkg::FN_CANCEL);
               state_in = (sts.func == iot_pkg::FN_EXEC) ? S_E_TRADE : S_IDLE;
            end
         end
         S_E_DEL: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               cmd.kind = iot_pkg::EV_DELETE;
               if (sts.func == iot_pkg::FN_REPLACE) begin
                  // rescan for the new reference after freeing the old slot
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN2;
               end else begin
                  cmd.last = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_E_TRADE: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               cmd.kind = iot_pkg::EV_TRADE;
               state_in = S_E_TTICK;
            end
         end
         S_E_TTICK: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               cmd.kind = iot_pkg::EV_TRADE_TICK;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_E_TICK: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               cmd.kind = iot_pkg::EV_TICK_SIZE;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

@@ sv/itch_order_tracker.sv @@
// Order tracker top level: turns decoded feed messages into order-book events.
//
// Input channel req_*: one decoded message per word, valid/ready handshake.
// Output channel rsp_*: zero to three event words per message, valid/ready;
// rsp_last marks the final event of a message. Messages that cause no event
// produce no word.
// Each message that touches the order table (add, executed, cancel, delete)
// runs one sequential scan over all ORDER_SLOTS table entries through the slot
// RAM read port; a replace whose original order is found runs a second scan.
// An add or trade message without a symbol first resolves it through the
// locate table. Trade and directory messages run no scan.
// A new message is taken once the previous one has loaded its last event; that
// event may still wait in the output register.
// After reset the locate table is cleared, one entry per cycle, over all
// LOCATE_ENTRIES entries (8192); req_ready stays low during that pass.
// When the receiver stalls, the pending event holds and the block waits.
`default_nettype none
module itch_order_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_order_ref,
   input  logic [63:0] req_orig_ref,
   input  logic [31:0] req_shares,
   input  logic [31:0] req_price,
   input  logic [1:0]  req_side_code,
   input  logic        req_has_symbol,
   input  logic [63:0] req_symbol,
   input  logic [15:0] req_locate,
   input  logic        req_has_seq,
   input  logic [63:0] req_seq,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [63:0] rsp_out_symbol,
   output logic [63:0] rsp_out_order_ref,
   output logic [1:0]  rsp_out_side,
   output logic [31:0] rsp_out_price,
   output logic [31:0] rsp_out_shares,
   output logic        rsp_out_has_seq,
   output logic [63:0] rsp_out_seq,
   output logic        rsp_last
);
   iot_pkg::cmd_type cmd;
   iot_pkg::sts_type sts;

   iot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   iot_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_order_ref     (req_order_ref),
      .req_orig_ref      (req_orig_ref),
      .req_shares        (req_shares),
      .req_price         (req_price),
      .req_side_code     (req_side_code),
      .req_has_symbol    (req_has_symbol),
      .req_symbol        (req_symbol),
      .req_locate        (req_locate),
      .req_has_seq       (req_has_seq),
      .req_seq           (req_seq),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_out_symbol    (rsp_out_symbol),
      .rsp_out_order_ref (rsp_out_order_ref),
      .rsp_out_side      (rsp_out_side),
      .rsp_out_price     (rsp_out_price),
      .rsp_out_shares    (rsp_out_shares),
      .rsp_out_has_seq   (rsp_out_has_seq),
      .rsp_out_seq       (rsp_out_seq),
      .rsp_last          (rsp_last)
   );
endmodule
`default_nettype wire
